// ===== design/arpc_pkg.sv =====
`timescale 1ns / 1ps
package arpc_pkg;

  // Relay and client table sizes
  localparam int RELAY_COUNT = 2;
  localparam int MAX_CLIENTS = 8;

  // Input item codes
  localparam logic [1:0] CMD_MSG   = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Report kinds and sources
  localparam logic       KIND_STATE = 1'b0;
  localparam logic       KIND_ERROR = 1'b1;
  localparam logic [1:0] SRC_GATEWAY = 2'd0;
  localparam logic [1:0] SRC_CLIENT  = 2'd1;
  localparam logic [1:0] SRC_TIMER   = 2'd2;

  // Configuration register indexes
  localparam logic [0:0] REG_TRUSTED_MAC  = 1'd0;
  localparam logic [0:0] REG_CLIENT_COUNT = 1'd1;

  localparam logic [32:0] COUNTER_WINDOW = 33'd50;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [47:0] sender_mac;
    logic [7:0]  channel;
    logic [31:0] msg_counter;
    logic [1:0]  relay_cmd;
    logic [31:0] push_ms;
    logic [15:0] battery;
    logic [2:0]  client_slot;
  } in_word_t;

  typedef struct packed {
    logic        report_kind;
    logic [1:0]  relay_id;
    logic        relay_on;
    logic [1:0]  source;
    logic [2:0]  client_index;
    logic [15:0] battery_out;
    logic [32:0] expected_low;
    logic [32:0] expected_high;
    logic [1:0]  relay_levels;
    logic        last;
  } out_word_t;

  // Classified job handed from front to back
  typedef enum logic [1:0] {
    JOB_TICK,
    JOB_RELAY,
    JOB_ERROR
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  channel;
    logic [1:0]  relay_cmd;
    logic [31:0] push_ms;
    logic [1:0]  source;
    logic [2:0]  client_index;
    logic [15:0] battery;
    logic [32:0] expected_low;
  } job_t;

endpackage

// ===== design/arpc_ram.sv =====
`timescale 1ns / 1ps
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/arpc_front.sv =====
`timescale 1ns / 1ps
module arpc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  arpc_pkg::in_word_t item,
  output logic              front_busy,
  input  logic [47:0]       trusted_mac,
  input  logic [3:0]        client_count,
  output logic              job_valid,
  output arpc_pkg::job_t    job,
  input  logic              job_ready
);
  import arpc_pkg::*;

  localparam int AW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CW = $clog2(MAX_CLIENTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_CMP, S_PUSH} state_t;

  state_t      state;
  in_word_t    cur;
  logic [CW-1:0] idx;
  logic [CW-1:0] lim;
  logic [AW-1:0] raddr, waddr;
  logic        we;
  logic [47:0] wmac, rmac;
  logic [31:0] wctr, rctr;
  logic [32:0] last_ext, ctr_ext;

  assign front_busy = (state != S_IDLE);
  assign raddr = idx[AW-1:0];
  assign last_ext = {1'b0, rctr};
  assign ctr_ext = {1'b0, cur.msg_counter};

  // Table write: entry writes from idle, counter update on a good compare
  always_comb begin
    we = 1'b0;
    waddr = item.client_slot[AW-1:0];
    wmac = item.sender_mac;
    wctr = item.msg_counter;
    if (state == S_IDLE && start && item.cmd == CMD_WRITE &&
        {29'd0, item.client_slot} < MAX_CLIENTS) begin
      we = 1'b1;
    end else if (state == S_CMP && rmac == cur.sender_mac &&
                 ctr_ext > last_ext && ctr_ext <= last_ext + COUNTER_WINDOW) begin
      we = 1'b1;
      waddr = idx[AW-1:0];
      wmac = rmac;
      wctr = cur.msg_counter;
    end
  end

  arpc_ram #(.WIDTH(48), .DEPTH(MAX_CLIENTS)) u_macs (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wmac), .raddr(raddr), .rdata(rmac));
  arpc_ram #(.WIDTH(32), .DEPTH(MAX_CLIENTS)) u_ctrs (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wctr), .raddr(raddr), .rdata(rctr));

  // Sequencer: classify, then search client table one entry at a time, a read state then a compare state per entry
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cur <= item;
            idx <= '0;
            lim <= (client_count > MAX_CLIENTS) ? CW'(MAX_CLIENTS) : CW'(client_count);
            job.kind <= JOB_TICK;
            job.channel <= item.channel;
            job.relay_cmd <= item.relay_cmd;
            job.push_ms <= item.push_ms;
            job.source <= SRC_GATEWAY;
            job.client_index <= '0;
            job.battery <= '0;
            job.expected_low <= '0;
            if (item.cmd == CMD_TICK) begin
              job_valid <= 1'b1;
              state <= S_PUSH;
            end else if (item.cmd == CMD_MSG && {24'd0, item.channel} <= RELAY_COUNT) begin
              if (item.sender_mac == trusted_mac) begin
                job.kind <= JOB_RELAY;
                job_valid <= (item.channel != 8'd0);
                state <= (item.channel != 8'd0) ? S_PUSH : S_IDLE;
              end else begin
                state <= S_READ;
              end
            end
          end
        end
        S_READ: begin
          if (idx >= lim) state <= S_IDLE;
          else state <= S_CMP;
        end
        S_CMP: begin
          if (rmac == cur.sender_mac) begin
            job.source <= SRC_CLIENT;
            job.client_index <= 3'(idx);
            if (we) begin
              job.kind <= JOB_RELAY;
              job.battery <= cur.battery;
              job_valid <= (cur.channel != 8'd0);
              state <= (cur.channel != 8'd0) ? S_PUSH : S_IDLE;
            end else begin
              job.kind <= JOB_ERROR;
              job.expected_low <= last_ext + 33'd1;
              job_valid <= 1'b1;
              state <= S_PUSH;
            end
          end else begin
            idx <= idx + CW'(1);
            state <= S_READ;
          end
        end
        S_PUSH: begin
          if (job_ready) begin
            job_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/arpc_queue.sv =====
`timescale 1ns / 1ps
module arpc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  arpc_pkg::job_t in_job,
  output logic           in_ready,
  output logic           out_valid,
  output arpc_pkg::job_t out_job,
  input  logic           out_ready
);
  import arpc_pkg::*;

  // Two-entry queue between classifier and executor
  job_t     slots [2];
  logic     wp, rp;
  logic [1:0] fill;
  logic     push, pop;

  assign in_ready = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_job = slots[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= in_job;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== design/arpc_back.sv =====
`timescale 1ns / 1ps
module arpc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  arpc_pkg::job_t     job,
  output logic               job_ready,
  output logic               back_busy,
  output logic               result_valid,
  output arpc_pkg::out_word_t result,
  output logic [arpc_pkg::RELAY_COUNT-1:0] levels
);
  import arpc_pkg::*;

  localparam int RW = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;

  typedef enum logic [1:0] {S_IDLE, S_TICK, S_PULSE} state_t;

  state_t      state;
  job_t        cur;
  logic [31:0] countdown [RELAY_COUNT];
  logic [RW-1:0] ri;
  logic [RW-1:0] tick_i;
  logic        any_left;
  logic [RELAY_COUNT-1:0] lv_on, lv_off;

  assign job_ready = (state == S_IDLE);
  assign back_busy = (state != S_IDLE);
  assign ri = RW'(job.channel - 8'd1);

  // Set or clear one relay bit
  always_comb begin
    lv_on = levels;
    lv_off = levels;
    lv_on[ri] = 1'b1;
    lv_off[ri] = 1'b0;
  end

  // Any later relay in the tick scan that will still release
  always_comb begin
    any_left = 1'b0;
    for (int k = 0; k < RELAY_COUNT; k++)
      if (k > int'(tick_i) && countdown[k] == 32'd1) any_left = 1'b1;
  end

  function automatic out_word_t mk(logic kind, logic [1:0] num, logic on,
                                   logic [1:0] src, logic [2:0] cidx,
                                   logic [15:0] bat, logic [32:0] lo,
                                   logic [1:0] lvl, logic lst);
    out_word_t w;
    w.report_kind = kind;
    w.relay_id = num;
    w.relay_on = on;
    w.source = src;
    w.client_index = cidx;
    w.battery_out = bat;
    w.expected_low = lo;
    w.expected_high = (kind == KIND_ERROR) ? lo + COUNTER_WINDOW - 33'd1 : 33'd0;
    w.relay_levels = lvl;
    w.last = lst;
    return w;
  endfunction

  // Executor: at most one report per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      levels <= '0;
      for (int k = 0; k < RELAY_COUNT; k++) countdown[k] <= '0;
      tick_i <= '0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur <= job;
            case (job.kind)
              JOB_TICK: begin
                tick_i <= '0;
                state <= S_TICK;
              end
              JOB_ERROR: begin
                result_valid <= 1'b1;
                result <= mk(KIND_ERROR, 2'd0, 1'b0, job.source, job.client_index,
                             16'd0, job.expected_low, 2'(levels), 1'b1);
              end
              JOB_RELAY: begin
                if (job.relay_cmd <= 2'd1) begin
                  result_valid <= 1'b1;
                  levels <= job.relay_cmd[0] ? lv_on : lv_off;
                  result <= mk(KIND_STATE, job.channel[1:0], job.relay_cmd[0],
                               job.source, job.client_index, job.battery, 33'd0,
                               2'(job.relay_cmd[0] ? lv_on : lv_off),
                               !(job.push_ms > 32'd1));
                  if (job.push_ms > 32'd1) state <= S_PULSE;
                end else if (job.push_ms > 32'd1) begin
                  state <= S_PULSE;
                end
              end
              default: ;
            endcase
          end
        end
        S_PULSE: begin
          countdown[RW'(cur.channel - 8'd1)] <= cur.push_ms;
          levels[RW'(cur.channel - 8'd1)] <= 1'b1;
          result_valid <= 1'b1;
          result <= mk(KIND_STATE, cur.channel[1:0], 1'b1, cur.source,
                       cur.client_index, cur.battery, 33'd0,
                       2'(levels | (RELAY_COUNT'(1) << RW'(cur.channel - 8'd1))), 1'b1);
          state <= S_IDLE;
        end
        S_TICK: begin
          if (countdown[tick_i] != 32'd0) begin
            countdown[tick_i] <= countdown[tick_i] - 32'd1;
            if (countdown[tick_i] == 32'd1) begin
              levels[tick_i] <= 1'b0;
              result_valid <= 1'b1;
              result <= mk(KIND_STATE, 2'(tick_i) + 2'd1, 1'b0, SRC_TIMER, 3'd0,
                           16'd0, 33'd0,
                           2'(levels & ~(RELAY_COUNT'(1) << tick_i)), !any_left);
            end
          end
          if (int'(tick_i) == RELAY_COUNT - 1) state <= S_IDLE;
          else tick_i <= tick_i + RW'(1);
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/authenticated_relay_pulse_controller.sv =====
`timescale 1ns / 1ps
// Relay controller with authenticated commands. One item is taken while busy is low;
// a client message runs the client table search, which reads one entry of the
// registered-read table memory at a time, with a read state and a compare state.
// Reports appear on result with result_valid high for one cycle each and cannot be
// held off; at most two come from one item, in consecutive cycles. relay_levels
// shows the drive levels.
module authenticated_relay_pulse_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  arpc_pkg::in_word_t   item,
  output logic                 result_valid,
  output arpc_pkg::out_word_t  result,
  output logic [arpc_pkg::RELAY_COUNT-1:0] relay_levels,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [47:0]          cfg_data
);
  import arpc_pkg::*;

  logic [47:0] trusted_mac;
  logic [3:0]  client_count;
  logic        front_busy, back_busy;
  logic        fj_valid, fj_ready, bj_valid, bj_ready;
  job_t        fj, bj;
  logic        q_pending;

  assign cfg_ready = 1'b1;
  assign q_pending = bj_valid;
  assign busy = front_busy || back_busy || q_pending;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trusted_mac <= '0;
      client_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TRUSTED_MAC:  trusted_mac <= cfg_data;
        REG_CLIENT_COUNT: client_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  arpc_front u_front (
    .clk(clk), .rst(rst), .start(start && !busy), .item(item), .front_busy(front_busy),
    .trusted_mac(trusted_mac), .client_count(client_count),
    .job_valid(fj_valid), .job(fj), .job_ready(fj_ready));

  arpc_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(fj_valid), .in_job(fj), .in_ready(fj_ready),
    .out_valid(bj_valid), .out_job(bj), .out_ready(bj_ready));

  arpc_back u_back (
    .clk(clk), .rst(rst), .job_valid(bj_valid), .job(bj), .job_ready(bj_ready),
    .back_busy(back_busy), .result_valid(result_valid), .result(result),
    .levels(relay_levels));

  // A report never appears while the block is idle with nothing queued
  a_no_stray: assert property (@(posedge clk) disable iff (rst)
    (!$past(busy) && !$past(start)) |-> !result_valid)
    else $error("report without work");
  // Error reports carry no relay number
  a_err_num: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.report_kind == KIND_ERROR) |-> result.relay_id == 2'd0)
    else $error("error report with relay number");
  // Reported levels match the driven levels
  a_levels: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.relay_levels == 2'(relay_levels))
    else $error("report levels differ");
endmodule

// ===== verif/authenticated_relay_pulse_controller_test.sv =====
`timescale 1ns / 1ps
module authenticated_relay_pulse_controller_test;
  import arpc_pkg::*;

  localparam int RELAYS = RELAY_COUNT;
  localparam int SLOTS = MAX_CLIENTS;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 24;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 530;

  localparam logic [47:0] GW_ADDR = 48'h02_00_5E_10_20_30;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_word_t    item;
  logic        result_valid;
  out_word_t   result;
  logic [RELAYS-1:0] relay_levels;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [47:0] cfg_data;

  authenticated_relay_pulse_controller dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_valid(result_valid),
    .result(result),
    .relay_levels(relay_levels),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Shadow copy of the controller state
  logic [47:0] gw_mac;
  logic [3:0]  paired_count;
  logic [47:0] paired_mac [SLOTS];
  logic [31:0] paired_ctr [SLOTS];
  logic [31:0] pulse_left [RELAYS];
  logic [RELAYS-1:0] drive_levels;

  out_word_t pending_reports [$];
  int errors = 0;
  int idle_cycles = 0;

  // Work out the reports one input word causes, updating the shadow state
  function automatic void predict_reports(input in_word_t w, ref out_word_t q[$]);
    out_word_t r;
    out_word_t made [$];
    logic [32:0] prev;
    logic [32:0] seen;
    logic [1:0] src;
    logic [2:0] idx;
    logic [15:0] bat;
    int lim;
    int hit;
    bit ok;
    int ri;
    if (w.cmd == CMD_WRITE) begin
      paired_mac[w.client_slot] = w.sender_mac;
      paired_ctr[w.client_slot] = w.msg_counter;
    end else if (w.cmd == CMD_TICK) begin
      for (int i = 0; i < RELAYS; i++) begin
        if (pulse_left[i] > 0) begin
          pulse_left[i]--;
          if (pulse_left[i] == 0) begin
            drive_levels[i] = 1'b0;
            r = '0;
            r.report_kind = KIND_STATE;
            r.relay_id = 2'(i + 1);
            r.source = SRC_TIMER;
            r.relay_levels = drive_levels;
            made.push_back(r);
          end
        end
      end
    end else if (w.cmd == CMD_MSG && w.channel <= RELAYS) begin
      src = SRC_GATEWAY;
      idx = '0;
      bat = '0;
      ok = 1'b1;
      if (w.sender_mac != gw_mac) begin
        lim = (paired_count < SLOTS) ? paired_count : SLOTS;
        hit = -1;
        for (int i = 0; i < lim; i++) begin
          if (hit < 0 && paired_mac[i] == w.sender_mac) hit = i;
        end
        if (hit < 0) begin
          ok = 1'b0;
        end else begin
          prev = {1'b0, paired_ctr[hit]};
          seen = {1'b0, w.msg_counter};
          if (seen <= prev || seen > prev + COUNTER_WINDOW) begin
            r = '0;
            r.report_kind = KIND_ERROR;
            r.source = SRC_CLIENT;
            r.client_index = 3'(hit);
            r.expected_low = prev + 33'd1;
            r.expected_high = prev + COUNTER_WINDOW;
            r.relay_levels = drive_levels;
            made.push_back(r);
            ok = 1'b0;
          end else begin
            paired_ctr[hit] = w.msg_counter;
            src = SRC_CLIENT;
            idx = 3'(hit);
            bat = w.battery;
          end
        end
      end
      if (ok && w.channel >= 1) begin
        ri = w.channel - 1;
        if (w.relay_cmd <= 2'd1) begin
          drive_levels[ri] = w.relay_cmd[0];
          r = '0;
          r.report_kind = KIND_STATE;
          r.relay_id = w.channel[1:0];
          r.relay_on = w.relay_cmd[0];
          r.source = src;
          r.client_index = idx;
          r.battery_out = bat;
          r.relay_levels = drive_levels;
          made.push_back(r);
        end
        if (w.push_ms > 1) begin
          pulse_left[ri] = w.push_ms;
          drive_levels[ri] = 1'b1;
          r = '0;
          r.report_kind = KIND_STATE;
          r.relay_id = w.channel[1:0];
          r.relay_on = 1'b1;
          r.source = src;
          r.client_index = idx;
          r.battery_out = bat;
          r.relay_levels = drive_levels;
          made.push_back(r);
        end
      end
    end
    if (made.size() > 0) made[$].last = 1'b1;
    foreach (made[i]) q.push_back(made[i]);
  endfunction

  function automatic void check_field(string name, logic [32:0] want, logic [32:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Compare each report word against the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && result_valid) begin
      if (pending_reports.size() == 0) begin
        $error("report word with nothing expected: %h", result);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("report_kind", 33'(want.report_kind), 33'(result.report_kind));
        check_field("relay_id", 33'(want.relay_id), 33'(result.relay_id));
        check_field("relay_on", 33'(want.relay_on), 33'(result.relay_on));
        check_field("source", 33'(want.source), 33'(result.source));
        check_field("client_index", 33'(want.client_index), 33'(result.client_index));
        check_field("battery_out", 33'(want.battery_out), 33'(result.battery_out));
        check_field("expected_low", want.expected_low, result.expected_low);
        check_field("expected_high", want.expected_high, result.expected_high);
        check_field("relay_levels", 33'(want.relay_levels), 33'(result.relay_levels));
        check_field("last", 33'(want.last), 33'(result.last));
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic in_word_t mk(logic [1:0] c, logic [47:0] m, logic [7:0] ch,
                                  logic [31:0] ctr, logic [1:0] rc, logic [31:0] p,
                                  logic [15:0] b, logic [2:0] s);
    in_word_t w;
    w.cmd = c;
    w.sender_mac = m;
    w.channel = ch;
    w.msg_counter = ctr;
    w.relay_cmd = rc;
    w.push_ms = p;
    w.battery = b;
    w.client_slot = s;
    return w;
  endfunction

  // Present one word; start stays high so back-to-back words need no extra edge
  task automatic send_word(input in_word_t w, input bit use_pred, ref out_word_t typed[$]);
    out_word_t scratch [$];
    @(negedge clk);
    item = w;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_reports(w, scratch);
    if (use_pred) foreach (scratch[i]) pending_reports.push_back(scratch[i]);
    else foreach (typed[i]) pending_reports.push_back(typed[i]);
  endtask

  task automatic pause(input int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic random_gap(input bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 50) return;
    if (roll < 90) pause($urandom_range(1, 3));
    else pause($urandom_range(10, 40));
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [47:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == REG_TRUSTED_MAC) gw_mac = val;
    else paired_count = val[3:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [31:0] rand_push();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(0, 6);
    if (roll < 97) return $urandom_range(0, 40);
    return $urandom;
  endfunction

  function automatic logic [7:0] rand_channel();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return 8'($urandom_range(0, RELAYS));
  endfunction

  // Random word: mostly well-formed client and gateway traffic, some noise
  function automatic in_word_t rand_word();
    int roll;
    int s;
    logic [31:0] ctr;
    roll = $urandom_range(0, 99);
    s = (paired_count == 0) ? 0 : $urandom_range(0, paired_count - 1);
    if (s >= SLOTS) s = $urandom_range(0, SLOTS - 1);
    if (roll < 38 && paired_count != 0) begin
      ctr = paired_ctr[s] + $urandom_range(1, 50);
      return mk(CMD_MSG, paired_mac[s], rand_channel(), ctr, 2'($urandom),
                rand_push(), 16'($urandom), 3'($urandom));
    end
    if (roll < 46 && paired_count != 0) begin
      if ($urandom_range(0, 1)) ctr = paired_ctr[s] - $urandom_range(0, 3);
      else ctr = paired_ctr[s] + $urandom_range(51, 60);
      return mk(CMD_MSG, paired_mac[s], rand_channel(), ctr, 2'($urandom),
                rand_push(), 16'($urandom), 3'($urandom));
    end
    if (roll < 62) begin
      return mk(CMD_MSG, gw_mac, rand_channel(), $urandom, 2'($urandom),
                rand_push(), 16'($urandom), 3'($urandom));
    end
    if (roll < 68) begin
      return mk(CMD_MSG, rand_mac(), rand_channel(), $urandom, 2'($urandom),
                rand_push(), 16'($urandom), 3'($urandom));
    end
    if (roll < 90) begin
      return mk(CMD_TICK, rand_mac(), 8'($urandom), $urandom, 2'($urandom),
                $urandom, 16'($urandom), 3'($urandom));
    end
    if ($urandom_range(0, 3) == 0) ctr = 32'hFFFF_FFFF - $urandom_range(0, 60);
    else ctr = $urandom;
    return mk(CMD_WRITE, ($urandom_range(0, 2) == 0) ? gw_mac : rand_mac(),
              8'($urandom), ctr, 2'($urandom), $urandom, 16'($urandom), 3'($urandom));
  endfunction

  typedef struct {
    in_word_t w;
    bit       typed;
    bit       one;
    out_word_t r;
  } row_t;

  row_t plan [$];
  out_word_t typed_q [$];
  out_word_t gw_on;
  int sent;

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_TRUSTED_MAC;
    cfg_data = '0;
    gw_mac = '0;
    paired_count = '0;
    drive_levels = '0;
    for (int i = 0; i < SLOTS; i++) begin
      paired_mac[i] = '0;
      paired_ctr[i] = '0;
    end
    for (int i = 0; i < RELAYS; i++) pulse_left[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(REG_TRUSTED_MAC, GW_ADDR);
    write_reg(REG_CLIENT_COUNT, 48'd8);

    gw_on = '0;
    gw_on.report_kind = KIND_STATE;
    gw_on.relay_id = 2'd1;
    gw_on.relay_on = 1'b1;
    gw_on.source = SRC_GATEWAY;
    gw_on.relay_levels = 2'b01;
    gw_on.last = 1'b1;

    // Directed table: typed rows carry their one expected word (or none)
    plan.push_back('{mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0), 1, 0, '0});
    plan.push_back('{mk(CMD_MSG, GW_ADDR, 1, 0, 1, 0, 16'hFFFF, 0), 1, 1, gw_on});
    plan.push_back('{mk(CMD_WRITE, 48'h1111, 0, 32'd0, 0, 0, 0, 0), 1, 0, '0});
    plan.push_back('{mk(CMD_WRITE, 48'h2222_3333, 0, 32'd100, 0, 0, 0, 1), 1, 0, '0});
    plan.push_back('{mk(CMD_WRITE, 48'h4444, 0, 32'd7, 0, 0, 0, 2), 1, 0, '0});
    plan.push_back('{mk(CMD_WRITE, 48'h5555, 0, 32'd9, 0, 0, 0, 3), 1, 0, '0});
    plan.push_back('{mk(CMD_WRITE, 48'h6666, 0, 32'd11, 0, 0, 0, 4), 1, 0, '0});
    plan.push_back('{mk(CMD_WRITE, 48'hFFFF_FFFF_FFFF, 0, 32'd5, 0, 0, 0, 5), 1, 0, '0});
    plan.push_back('{mk(CMD_WRITE, GW_ADDR, 0, 32'd0, 0, 0, 0, 6), 1, 0, '0});
    plan.push_back('{mk(CMD_WRITE, 48'h7777, 0, 32'hFFFF_FFF0, 0, 0, 0, 7), 1, 0, '0});
    // gateway: off plus pulse, two words
    plan.push_back('{mk(CMD_MSG, GW_ADDR, 2, 0, 0, 32'd3, 0, 0), 0, 0, '0});
    // absent and out-of-range channel, unknown sender
    plan.push_back('{mk(CMD_MSG, GW_ADDR, 99, 0, 1, 5, 0, 0), 1, 0, '0});
    plan.push_back('{mk(CMD_MSG, GW_ADDR, 255, 0, 1, 5, 0, 0), 1, 0, '0});
    plan.push_back('{mk(CMD_MSG, 48'hABCD, 1, 1, 1, 0, 0, 0), 1, 0, '0});
    // client in window, replayed counter, far counter
    plan.push_back('{mk(CMD_MSG, 48'h2222_3333, 1, 101, 0, 0, 16'hFFFF, 0), 0, 0, '0});
    plan.push_back('{mk(CMD_MSG, 48'h2222_3333, 1, 101, 1, 0, 16'h1234, 0), 0, 0, '0});
    plan.push_back('{mk(CMD_MSG, 48'h2222_3333, 2, 152, 1, 0, 0, 0), 0, 0, '0});
    // counter at top of range, then wrapped value rejected
    plan.push_back('{mk(CMD_MSG, 48'h7777, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 7, 0),
                     0, 0, '0});
    plan.push_back('{mk(CMD_MSG, 48'h7777, 1, 32'd0, 1, 0, 0, 0), 0, 0, '0});
    // channel zero: counter only
    plan.push_back('{mk(CMD_MSG, 48'hFFFF_FFFF_FFFF, 0, 6, 1, 9, 0, 0), 0, 0, '0});
    // push without switch, one-tick duration means none
    plan.push_back('{mk(CMD_MSG, 48'hFFFF_FFFF_FFFF, 2, 50, 2'd3, 2, 16'h8001, 0), 0, 0, '0});
    plan.push_back('{mk(CMD_MSG, 48'h1111, 1, 1, 2'd2, 1, 0, 0), 0, 0, '0});
    plan.push_back('{mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0), 0, 0, '0});
    plan.push_back('{mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0), 0, 0, '0});
    plan.push_back('{mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0), 0, 0, '0});

    foreach (plan[i]) begin
      typed_q.delete();
      if (plan[i].one) typed_q.push_back(plan[i].r);
      send_word(plan[i].w, !plan[i].typed, typed_q);
      random_gap(1'b0);
    end
    drain();

    // Random phases with several register settings
    sent = 0;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_TRUSTED_MAC, 48'h0);
          write_reg(REG_CLIENT_COUNT, 48'd0);
        end
        1: begin
          write_reg(REG_TRUSTED_MAC, 48'hFFFF_FFFF_FFFF);
          write_reg(REG_CLIENT_COUNT, 48'd8);
        end
        2: begin
          write_reg(REG_TRUSTED_MAC, paired_mac[$urandom_range(0, SLOTS - 1)]);
          write_reg(REG_CLIENT_COUNT, 48'd1);
        end
        default: begin
          write_reg(REG_TRUSTED_MAC, rand_mac());
          write_reg(REG_CLIENT_COUNT, 48'($urandom_range(0, 8)));
        end
      endcase
      for (int k = 0; k < RANDOM_ITEMS / 7; k++) begin
        send_word(rand_word(), 1'b1, typed_q);
        sent++;
        random_gap(ph == 4);
      end
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
